FILE: src/szd_pkg.sv
// ----------------------------------------------------------------------------
// szd_pkg: shared types and constants of the smoothed z-score detector
// Holds the sequencer states, the signal codes, the configuration register
// indexes and the verdict record passed from the test datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package szd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int THRESHOLD_W = 16;
  localparam int INFLUENCE_W = 9;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAC_W      = 8;

  localparam logic [INFLUENCE_W-1:0] INFL_ONE = 9'd256;

  localparam logic signed [1:0] SIG_ZERO = 2'sb00;
  localparam logic signed [1:0] SIG_POS  = 2'sb01;
  localparam logic signed [1:0] SIG_NEG  = 2'sb11;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_INFLUENCE = 1'b1
  } szd_cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STATS,
    ST_SPREAD,
    ST_PRODUCT,
    ST_DECIDE,
    ST_COMMIT
  } szd_state_t;

  typedef struct packed {
    logic                  flag;
    logic                  pos;
    logic [SAMPLE_W-1:0]   old;
    logic [2*SAMPLE_W-1:0] old_sq;
  } szd_verdict_t;

endpackage

`default_nettype wire

FILE: src/szd_ram.sv
// ----------------------------------------------------------------------------
// szd_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module szd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/szd_detect.sv
// ----------------------------------------------------------------------------
// szd_detect: deviation test datapath
// Three register stages compare the squared deviation of a sample with the
// squared threshold times the window variance, both scaled by WINDOW_LENGTH
// squared. The threshold product is formed from two half-width partials.
// ----------------------------------------------------------------------------
`default_nettype none

module szd_detect
  import szd_pkg::*;
#(
  parameter int WINDOW_LENGTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic [SAMPLE_W-1:0]                       x,
  input  wire logic [SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0] sum,
  input  wire logic [2*SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0] square_sum,
  input  wire logic [THRESHOLD_W-1:0]                    threshold,
  input  wire logic [SAMPLE_W-1:0]                       old,
  output szd_verdict_t                                   verdict
);

  localparam int LN = $clog2(WINDOW_LENGTH);
  localparam int SW = SAMPLE_W + LN;
  localparam int VW = 2 * SW;
  localparam int TW = 2 * THRESHOLD_W;
  localparam int PW = TW + SW;
  localparam int CW = TW + VW;

  logic [SW-1:0]       nx;
  logic [SW-1:0]       dev1;
  logic                pos1;
  logic [VW-1:0]       ss1;
  logic [TW-1:0]       thr2_1;
  logic [SAMPLE_W-1:0] old1;

  logic [VW-1:0]         var2;
  logic [VW-1:0]         dsq2;
  logic [2*SAMPLE_W-1:0] osq2;
  logic                  pos2;
  logic [TW-1:0]         thr2_2;

  logic [PW-1:0] plo3;
  logic [PW-1:0] phi3;
  logic [VW-1:0] dsq3;
  logic          pos3;

  logic [CW-1:0] lhs;
  logic [CW-1:0] rhs;

  assign nx = SW'(WINDOW_LENGTH) * SW'(x);

  always_ff @(posedge clk) begin
    pos1   <= nx > sum;
    dev1   <= (nx >= sum) ? nx - sum : sum - nx;
    ss1    <= VW'(sum) * VW'(sum);
    thr2_1 <= TW'(threshold) * TW'(threshold);
    old1   <= old;

    var2   <= VW'(WINDOW_LENGTH) * VW'(square_sum) - ss1;
    dsq2   <= VW'(dev1) * VW'(dev1);
    osq2   <= (2 * SAMPLE_W)'(old1) * (2 * SAMPLE_W)'(old1);
    pos2   <= pos1;
    thr2_2 <= thr2_1;

    plo3 <= PW'(thr2_2) * PW'(var2[SW-1:0]);
    phi3 <= PW'(thr2_2) * PW'(var2[VW-1:SW]);
    dsq3 <= dsq2;
    pos3 <= pos2;
  end

  assign lhs = CW'({dsq3, 16'h0000});
  assign rhs = (CW'(phi3) << SW) + CW'(plo3);

  assign verdict.flag   = lhs > rhs;
  assign verdict.pos    = pos3;
  assign verdict.old    = old1;
  assign verdict.old_sq = osq2;

endmodule

`default_nettype wire

FILE: src/smoothed_zscore_peak_detector_unit.sv
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detector_unit: sliding-window z-score peak detector
// Takes one range sample per request and answers each with one result:
// a signal of +1, -1 or 0 and a flag that detection is active.
//
// The input channel (in_valid, in_ready, sample) is ready only while the
// sequencer is idle. The first WINDOW_LENGTH samples fill the window and
// their results go straight from acceptance to the commit step. Every
// later sample runs through the test datapath (window statistics,
// variance, threshold partial products, decision) before its commit,
// and the block takes no new sample until the last one has committed.
// The window entries live in a RAM; the running sums, the oldest pointer
// and the fill count live in registers. A result waits in the output
// register while out_ready is low; a new sample is accepted meanwhile, and
// its own update waits in the commit step until the output register frees.
// Reset empties the window and restores the default threshold and influence.
// The user must write the configuration port (cfg_we, cfg_index, cfg_data)
// only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_zscore_peak_detector_unit
  import szd_pkg::*;
#(
  parameter int WINDOW_LENGTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_W-1:0]    sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [1:0]           signal,
  output logic                        window_full,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LN = $clog2(WINDOW_LENGTH);
  localparam int SW = SAMPLE_W + LN;
  localparam int QW = 2 * SAMPLE_W + LN;
  localparam int FW = $clog2(WINDOW_LENGTH + 1);
  localparam int BW = INFLUENCE_W + SAMPLE_W + 1;

  szd_state_t state;
  szd_state_t state_next;

  logic [THRESHOLD_W-1:0] threshold;
  logic [INFLUENCE_W-1:0] influence;

  logic [LN-1:0]       oldest_pointer;
  logic [FW-1:0]       fill_count;
  logic [SAMPLE_W-1:0] newest_value;
  logic [SW-1:0]       window_sum;
  logic [QW-1:0]       window_square_sum;

  logic [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0] blend;
  logic [SAMPLE_W-1:0] value;
  logic signed [1:0]   sig;
  logic                full;

  logic                   accept;
  logic                   commit;
  logic                   filled;
  logic [INFLUENCE_W-1:0] infl_sat;
  logic [BW-1:0]          blend_sum;
  logic [2*SAMPLE_W-1:0]  value_sq;
  logic [SAMPLE_W-1:0]    drop_value;
  logic [2*SAMPLE_W-1:0]  drop_sq;
  logic [SAMPLE_W-1:0]    ram_rdata;
  szd_verdict_t           verdict;

  szd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW_LENGTH)
  ) u_window (
    .clk  (clk),
    .we   (commit),
    .waddr(oldest_pointer),
    .wdata(value),
    .raddr(oldest_pointer),
    .rdata(ram_rdata)
  );

  szd_detect #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_detect (
    .clk       (clk),
    .x         (x),
    .sum       (window_sum),
    .square_sum(window_square_sum),
    .threshold (threshold),
    .old       (ram_rdata),
    .verdict   (verdict)
  );

  assign filled    = fill_count == FW'(WINDOW_LENGTH);
  assign infl_sat  = (influence > INFL_ONE) ? INFL_ONE : influence;
  assign blend_sum = BW'(infl_sat) * BW'(sample)
                   + BW'(INFL_ONE - infl_sat) * BW'(newest_value);
  assign value_sq  = (2 * SAMPLE_W)'(value) * (2 * SAMPLE_W)'(value);
  assign drop_value = full ? verdict.old : '0;
  assign drop_sq    = full ? verdict.old_sq : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    accept     = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (in_valid) begin
          state_next = filled ? ST_STATS : ST_COMMIT;
        end
      end
      ST_STATS:   state_next = ST_SPREAD;
      ST_SPREAD:  state_next = ST_PRODUCT;
      ST_PRODUCT: state_next = ST_DECIDE;
      ST_DECIDE:  state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd896;
      influence <= 9'd128;
    end else if (cfg_we) begin
      unique case (szd_cfg_index_t'(cfg_index))
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_INFLUENCE: influence <= cfg_data[INFLUENCE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x     <= sample;
      blend <= blend_sum[FRAC_W +: SAMPLE_W];
      value <= sample;
      sig   <= SIG_ZERO;
      full  <= filled;
    end else if (state == ST_DECIDE) begin
      if (verdict.flag) begin
        value <= blend;
        sig   <= verdict.pos ? SIG_POS : SIG_NEG;
      end else begin
        value <= x;
        sig   <= SIG_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_pointer    <= '0;
      fill_count        <= '0;
      newest_value      <= '0;
      window_sum        <= '0;
      window_square_sum <= '0;
    end else if (commit) begin
      oldest_pointer    <= (oldest_pointer == LN'(WINDOW_LENGTH - 1)) ? '0
                         : oldest_pointer + 1'b1;
      fill_count        <= filled ? fill_count : fill_count + 1'b1;
      newest_value      <= value;
      window_sum        <= window_sum - SW'(drop_value) + SW'(value);
      window_square_sum <= window_square_sum - QW'(drop_sq) + QW'(value_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      signal      <= sig;
      window_full <= full;
    end
  end

endmodule

`default_nettype wire
